// ----- src/fpdr_pkg.sv -----
package fpdr_pkg;

  // Field widths
  localparam int unsigned END_W  = 48;
  localparam int unsigned OFF_W  = 24;
  localparam int unsigned WL_W   = 24;
  localparam int unsigned SPB_W  = 11;
  localparam int unsigned QS_W   = 24;
  localparam int unsigned BKT_W  = 48;

  // Register port
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] REG_WINDOW_LENGTH   = 2'd0;
  localparam logic [1:0] REG_SAMPLES_PER_BIT = 2'd1;
  localparam logic [1:0] REG_QUANT_STEP      = 2'd2;

  localparam logic [WL_W-1:0]  WL_RESET  = 24'd14400;
  localparam logic [SPB_W-1:0] SPB_RESET = 11'd1;
  localparam logic [QS_W-1:0]  QS_RESET  = 24'd960;

  typedef struct packed {
    logic [END_W-1:0] window_end_count;
    logic [OFF_W-1:0] sync_offset;
  } in_item_t;

  typedef struct packed {
    logic             is_new;
    logic [BKT_W-1:0] bucket;
  } out_item_t;

  // Ring scan status
  typedef struct packed {
    logic done;
    logic is_new;
  } ring_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POS,
    S_DIV,
    S_RING,
    S_OUT
  } state_e;

endpackage

// ----- src/fpdr_ram.sv -----
module fpdr_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/fpdr_pos.sv -----
module fpdr_pos (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fpdr_pkg::END_W-1:0] end_i,
  input  logic [fpdr_pkg::OFF_W-1:0] off_i,
  input  logic [fpdr_pkg::WL_W-1:0]  wl_i,
  input  logic [fpdr_pkg::SPB_W-1:0] spb_i,
  output logic                       done_o,
  output logic [fpdr_pkg::END_W-1:0] pos_o
);
  import fpdr_pkg::*;

  localparam int unsigned CNT_W = $clog2(SPB_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [END_W-1:0] acc_q, acc_d;
  logic [END_W-1:0] off_sh_q, off_sh_d;
  logic [SPB_W-1:0] spb_sh_q, spb_sh_d;
  logic [SPB_W-2:0] half_q, half_d;

  // Shift-add: one multiplier bit per cycle, half a bit added last.
  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    off_sh_d = off_sh_q;
    spb_sh_d = spb_sh_q;
    half_d   = half_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      acc_d    = end_i - END_W'(wl_i);
      off_sh_d = END_W'(off_i);
      spb_sh_d = spb_i;
      half_d   = spb_i[SPB_W-1:1];
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(SPB_W)) begin
        acc_d  = acc_q + END_W'(half_q);
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (spb_sh_q[0]) begin
          acc_d = acc_q + off_sh_q;
        end
        off_sh_d = {off_sh_q[END_W-2:0], 1'b0};
        spb_sh_d = spb_sh_q >> 1;
        cnt_d    = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    off_sh_q <= off_sh_d;
    spb_sh_q <= spb_sh_d;
    half_q   <= half_d;
  end

  assign done_o = done_q;
  assign pos_o  = acc_q;

endmodule

// ----- src/fpdr_div.sv -----
module fpdr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fpdr_pkg::BKT_W-1:0] dividend_i,
  input  logic [fpdr_pkg::QS_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [fpdr_pkg::BKT_W-1:0] quo_o
);
  import fpdr_pkg::*;

  localparam int unsigned CNT_W = $clog2(BKT_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BKT_W-1:0] quo_q, quo_d;
  logic [QS_W-1:0]  rem_q, rem_d;
  logic [QS_W-1:0]  dvs_q, dvs_d;
  logic [QS_W:0]    trial;
  logic             ge;

  // Restoring divide: dividend bits leave the top of quo_q, quotient bits enter at the bottom.
  assign trial = {rem_q, quo_q[BKT_W-1]} - {1'b0, dvs_q};
  assign ge    = ~trial[QS_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = (divisor_i == '0) ? QS_W'(1) : divisor_i;   // zero step acts as one
    end else if (busy_q) begin
      rem_d = ge ? trial[QS_W-1:0] : {rem_q[QS_W-2:0], quo_q[BKT_W-1]};
      quo_d = {quo_q[BKT_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(BKT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- src/fpdr_ring.sv -----
module fpdr_ring #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fpdr_pkg::BKT_W-1:0] bucket_i,
  output fpdr_pkg::ring_stat_t       stat_o
);
  import fpdr_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic             busy_q, busy_d;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  ring_stat_t       stat_q, stat_d;
  logic [BKT_W-1:0] bkt_q, bkt_d;
  logic [BKT_W-1:0] rd_data;
  logic             we;
  logic             hit;

  fpdr_ram #(
    .WIDTH(BKT_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wp_q),
    .wdata_i(bkt_q),
    .raddr_i(cnt_q[IDX_W-1:0]),
    .rdata_o(rd_data)
  );

  // Read data of the entry issued last cycle is compared here.
  assign hit = pend_q && (rd_data == bkt_q);

  always_comb begin
    busy_d        = busy_q;
    pend_d        = 1'b0;
    cnt_d         = cnt_q;
    wp_d          = wp_q;
    fill_d        = fill_q;
    bkt_d         = bkt_q;
    stat_d.done   = 1'b0;
    stat_d.is_new = stat_q.is_new;
    we            = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bkt_d  = bucket_i;
    end else if (busy_q) begin
      if (hit) begin
        busy_d        = 1'b0;
        stat_d.done   = 1'b1;
        stat_d.is_new = 1'b0;
      end else if (cnt_q < fill_q) begin
        pend_d = 1'b1;
        cnt_d  = cnt_q + CNT_W'(1);
      end else begin
        // all filled entries seen: store as new
        busy_d        = 1'b0;
        stat_d.done   = 1'b1;
        stat_d.is_new = 1'b1;
        we            = 1'b1;
        wp_d          = (wp_q == IDX_W'(DEPTH - 1)) ? '0 : wp_q + IDX_W'(1);
        fill_d        = (fill_q == CNT_W'(DEPTH)) ? fill_q : fill_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      cnt_q  <= '0;
      wp_q   <= '0;
      fill_q <= '0;
      stat_q <= '0;
    end else begin
      busy_q <= busy_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      wp_q   <= wp_d;
      fill_q <= fill_d;
      stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bkt_q <= bkt_d;
  end

  assign stat_o = stat_q;

endmodule

// ----- src/frame_position_dedup_ring_top.sv -----
// Sync position dedup. Each input item is one sync-word detection report: the
// absolute sample count at the end of the decode window and the bit offset of
// the sync inside it. The block forms the absolute sample position
// (count - window_length + offset * samples_per_bit + samples_per_bit / 2,
// modulo 2^48), divides it by quant_step (zero is taken as one) to get a
// bucket, and looks the bucket up among the last RING_DEPTH new buckets. One
// result item per input item: is_new and the bucket. A new bucket replaces the
// oldest ring entry. One item is in work at a time; an item passes through
// the bit-serial position multiply, the 48-step divider and the ring scan,
// which reads one entry per cycle from a single-port-read RAM, stopping at
// the first match, before its result is loaded into the output register.
// The output register lets the next item be accepted while a result waits.
// Registers sit on an APB port at 0x0 window_length, 0x4 samples_per_bit,
// 0x8 quant_step; write them only while idle. Ring contents need no
// clearing after reset: only entries below the fill count are read.
module frame_position_dedup_ring_top #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  fpdr_pkg::in_item_t          in_item_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output fpdr_pkg::out_item_t         out_item_o,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpdr_pkg::ADDR_W-1:0] paddr,
  input  logic [fpdr_pkg::DATA_W-1:0] pwdata,
  output logic [fpdr_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import fpdr_pkg::*;

  state_e state_q, state_d;

  logic [WL_W-1:0]  wl_q;
  logic [SPB_W-1:0] spb_q;
  logic [QS_W-1:0]  qs_q;
  logic             cfg_wr;

  logic             accept;
  logic             load_out;
  logic             pos_done;
  logic [END_W-1:0] pos;
  logic             div_done;
  logic [BKT_W-1:0] quo;
  ring_stat_t       ring_stat;

  logic             out_valid_q;
  out_item_t        out_item_q;

  // ---------------- register port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q  <= WL_RESET;
      spb_q <= SPB_RESET;
      qs_q  <= QS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WINDOW_LENGTH:   wl_q  <= pwdata[WL_W-1:0];
        REG_SAMPLES_PER_BIT: spb_q <= pwdata[SPB_W-1:0];
        REG_QUANT_STEP:      qs_q  <= pwdata[QS_W-1:0];
        default: ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW_LENGTH:   prdata = DATA_W'(wl_q);
      REG_SAMPLES_PER_BIT: prdata = DATA_W'(spb_q);
      REG_QUANT_STEP:      prdata = DATA_W'(qs_q);
      default:             prdata = '0;
    endcase
  end

  // ---------------- datapath units ----------------
  // position: bit-serial multiply-add, latches the item at accept
  fpdr_pos u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .end_i  (in_item_i.window_end_count),
    .off_i  (in_item_i.sync_offset),
    .wl_i   (wl_q),
    .spb_i  (spb_q),
    .done_o (pos_done),
    .pos_o  (pos)
  );

  // bucket: one quotient bit per cycle
  fpdr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (pos_done),
    .dividend_i(pos),
    .divisor_i (qs_q),
    .done_o    (div_done),
    .quo_o     (quo)
  );

  // ring lookup and insert; quo holds until the next item
  fpdr_ring #(
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_done),
    .bucket_i(quo),
    .stat_o  (ring_stat)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i)             state_d = S_POS;
      S_POS:  if (pos_done)               state_d = S_DIV;
      S_DIV:  if (div_done)               state_d = S_RING;
      S_RING: if (ring_stat.done)         state_d = S_OUT;
      S_OUT:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default:                            state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_OUT:   load_out   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign accept = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_item_q.is_new <= ring_stat.is_new;
      out_item_q.bucket <= quo;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  // the three units hand over in turn, never finishing together
  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({pos_done, div_done, ring_stat.done}))
    else $error("more than one unit finished in the same cycle");

  a_pos_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_done |-> state_q == S_POS)
    else $error("position finished outside its phase");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside its phase");

  a_ring_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_stat.done |=> state_q == S_OUT && !in_ready_o)
    else $error("ring result not moved to output stage");
`endif

endmodule

// ----- bench/fpdr_bucket_checker.sv -----
module fpdr_bucket_checker #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  fpdr_pkg::in_item_t          in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  fpdr_pkg::out_item_t         out_item_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [fpdr_pkg::ADDR_W-1:0] paddr_i,
  input  logic [fpdr_pkg::DATA_W-1:0] pwdata_i,
  input  logic                        pready_i,
  output int                          mismatch_count_o,
  output int                          pending_o,
  output int                          checked_o,
  output int                          fresh_o
);
  import fpdr_pkg::*;

  // shadow registers
  logic [WL_W-1:0]  win_len;
  logic [SPB_W-1:0] spb;
  logic [QS_W-1:0]  qstep;

  // shadow of the dedup ring
  logic [BKT_W-1:0] recent [RING_DEPTH];
  int unsigned      ring_wr;
  int unsigned      ring_fill;

  out_item_t bucket_verdicts [$];
  int        mismatches;
  int        checked;
  int        fresh;

  // Bucket of one report, and whether the ring has seen it; updates the ring.
  function automatic out_item_t classify_report(in_item_t rpt);
    logic [BKT_W-1:0] start;
    logic [BKT_W-1:0] pos;
    logic [BKT_W-1:0] off_w;
    logic [BKT_W-1:0] spb_w;
    logic [BKT_W-1:0] step;
    out_item_t        verdict;
    start  = rpt.window_end_count - BKT_W'(win_len);
    off_w  = BKT_W'(rpt.sync_offset);
    spb_w  = BKT_W'(spb);
    pos    = start + off_w * spb_w + (spb_w >> 1);
    step   = (qstep == '0) ? BKT_W'(1) : BKT_W'(qstep);
    verdict.bucket = pos / step;
    verdict.is_new = 1'b1;
    for (int unsigned i = 0; i < ring_fill; i++) begin
      if (recent[i] == verdict.bucket) verdict.is_new = 1'b0;
    end
    if (verdict.is_new) begin
      recent[ring_wr] = verdict.bucket;
      ring_wr = (ring_wr + 1) % RING_DEPTH;
      if (ring_fill < RING_DEPTH) ring_fill++;
    end
    return verdict;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      win_len    = WL_RESET;
      spb        = SPB_RESET;
      qstep      = QS_RESET;
      ring_wr    = 0;
      ring_fill  = 0;
      bucket_verdicts.delete();
      mismatches = 0;
      checked    = 0;
      fresh      = 0;
    end else begin
      // results first: an item taken this edge cannot have its result yet
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (bucket_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %0d: is_new=%0b bucket=%h",
                     checked, out_item_i.is_new, out_item_i.bucket);
        end else begin
          want = bucket_verdicts.pop_front();
          if (want.is_new) fresh++;
          if (want.is_new !== out_item_i.is_new || want.bucket !== out_item_i.bucket) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected is_new=%0b bucket=%h, got is_new=%0b bucket=%h",
                       checked, want.is_new, want.bucket,
                       out_item_i.is_new, out_item_i.bucket);
          end
        end
      end
      if (in_valid_i && in_ready_i) bucket_verdicts.push_back(classify_report(in_item_i));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[ADDR_W-1:2])
          REG_WINDOW_LENGTH:   win_len = pwdata_i[WL_W-1:0];
          REG_SAMPLES_PER_BIT: spb     = pwdata_i[SPB_W-1:0];
          REG_QUANT_STEP:      qstep   = pwdata_i[QS_W-1:0];
          default: ;
        endcase
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= bucket_verdicts.size();
    checked_o        <= checked;
    fresh_o          <= fresh;
  end

endmodule

// ----- bench/frame_position_dedup_ring_top_test.sv -----
module frame_position_dedup_ring_top_test;
  import fpdr_pkg::*;

  localparam int unsigned RING_DEPTH       = 64;
  localparam int          NUM_PHASES       = 7;
  localparam int          RANDOM_PER_PHASE = 185;
  localparam int          HISTORY_DEPTH    = 100;  // longer than the ring: evicted buckets recur
  // no register lives here; writes to it must be dropped
  localparam logic [1:0]  REG_UNUSED       = 2'd3;

  // Register settings per phase; phase 0 runs on reset values. Upper junk bits
  // check that only the register width is taken.
  localparam logic [31:0] WL_TAB [NUM_PHASES] = '{
    32'h0000_3840, 32'hFF00_0001, 32'h00FF_FFFF, 32'h0000_BB80,
    32'hA500_3840, 32'h0000_12C0, 32'h0000_3840};
  localparam logic [31:0] SPB_TAB [NUM_PHASES] = '{
    32'h0000_0001, 32'hFFFF_F400, 32'h0000_07FF, 32'h0000_0005,
    32'hFFFF_F800, 32'h0000_0014, 32'h0000_0001};
  localparam logic [31:0] QS_TAB [NUM_PHASES] = '{
    32'h0000_03C0, 32'h0000_0001, 32'h00FF_FFFF, 32'h7F00_0000,
    32'h0000_03C0, 32'h0000_0060, 32'h0000_03C0};

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_item;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatch_count;
  int pending;
  int checked;
  int fresh;

  // stimulus-side copies of the registers, to aim reports at known positions
  logic [WL_W-1:0]  cfg_wl  = WL_RESET;
  logic [SPB_W-1:0] cfg_spb = SPB_RESET;
  logic [QS_W-1:0]  cfg_qs  = QS_RESET;

  logic             idle_en = 1'b1;  // random gaps on both sides
  int               hold_cnt = 0;
  int               sent = 0;
  logic [47:0]      seen_pos [$];    // sync positions already reported
  logic [47:0]      last_pos = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  frame_position_dedup_ring_top #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  fpdr_bucket_checker #(
    .RING_DEPTH (RING_DEPTH)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_item_i       (out_item),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .fresh_o          (fresh)
  );

  // Result side: random stall bursts between ready runs; always
  // ready once idling is off.
  always @(posedge clk) begin
    if (!idle_en) begin
      out_ready <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
      hold_cnt  <= $urandom_range(0, 15);
    end
  end

  // One report. Valid stays up after the accept so back-to-back items never
  // drop it; anything that lets time pass lowers it first.
  task automatic send_report(input logic [47:0] end_cnt, input logic [23:0] offset);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= {end_cnt, offset};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Hold off input until every expected result is back. Always waits on a
  // clock edge, so valid is never lowered and raised in one step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // setup cycle, access cycle, then a quiet cycle so psel is not re-raised
  // in the step it drops
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly windows that re-detect a sync already seen (same position from a
  // later window, sometimes a few samples off), then new syncs, then noise.
  task automatic send_random_report();
    int          pick;
    logic [47:0] pos;
    logic [47:0] end_cnt;
    logic [47:0] off_w;
    logic [47:0] spb_w;
    logic [23:0] offset;
    pick = $urandom_range(0, 99);
    if (pick >= 85) begin
      end_cnt = {16'($urandom), $urandom};
      offset  = 24'($urandom);
    end else begin
      if (pick < 55 && seen_pos.size() > 0) begin
        pos = seen_pos[$urandom_range(0, seen_pos.size() - 1)];
        if ($urandom_range(0, 3) == 0) pos = pos + 48'($urandom_range(0, 3));
      end else begin
        if ($urandom_range(0, 1) == 1) pos = {16'($urandom), $urandom};
        else pos = last_pos + 48'($urandom_range(1, 40000));
        seen_pos.push_back(pos);
        if (seen_pos.size() > HISTORY_DEPTH) void'(seen_pos.pop_front());
        last_pos = pos;
      end
      // back out the window end that puts the sync at pos
      offset  = 24'($urandom_range(0, 3000));
      off_w   = 48'(offset);
      spb_w   = 48'(cfg_spb);
      end_cnt = pos + 48'(cfg_wl) - off_w * spb_w - (spb_w >> 1);
    end
    send_report(end_cnt, offset);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, on reset settings (window 14400, 1 sample/bit, step 960)
    send_report(48'd0, 24'd0);                           // window start wraps below zero
    send_report(48'hFFFF_FFFF_FFFF, 24'hFF_FFFF);        // sum wraps past 2^48
    send_report(48'd14400, 24'd0);                       // position 0, new
    send_report(48'd14400, 24'd0);                       // exact duplicate
    send_report(48'd15359, 24'd0);                       // last sample of bucket 0
    send_report(48'd15360, 24'd0);                       // first sample of bucket 1
    send_report(48'd20000, 24'd100);                     // sync seen in one window...
    send_report(48'd20050, 24'd50);                      // ...and again in the next one
    send_report(48'hAAAA_AAAA_AAAA, 24'h55_5555);
    send_report(48'h5555_5555_5555, 24'hAA_AAAA);
    send_report(48'hFFFF_FFFF_FFFF, 24'd0);
    send_report(48'd14399, 24'd1);                       // wrapped start lands on 0 again

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_reg(REG_WINDOW_LENGTH,   WL_TAB[ph]);
        write_reg(REG_SAMPLES_PER_BIT, SPB_TAB[ph]);
        write_reg(REG_QUANT_STEP,      QS_TAB[ph]);
        if (ph == 3) write_reg(REG_UNUSED, 32'hDEAD_BEEF);  // must change nothing
        cfg_wl  = WL_TAB[ph][WL_W-1:0];
        cfg_spb = SPB_TAB[ph][SPB_W-1:0];
        cfg_qs  = QS_TAB[ph][QS_W-1:0];
      end
      if (ph == NUM_PHASES - 1) idle_en <= 1'b0;  // last phase at full rate
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // sender pause mid-phase, except in the full-rate phase
        if (ph != NUM_PHASES - 1 && n == RANDOM_PER_PHASE / 2) wait_drained();
        send_random_report();
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);

    $display("covered %0d reports over %0d register settings incl. zero step and zero spb",
             sent, NUM_PHASES);
    $display("checked %0d results, %0d new buckets, %0d mismatches, %0d still pending",
             checked, fresh, mismatch_count, pending);
    if (mismatch_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // guard: several times the slowest legal run
  initial begin
    #12_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
